// ----- hdl/four_channel_pwm_timer_assert.svh -----
// assertion macros for the four-channel pwm timer checker
`ifndef FOUR_CHANNEL_PWM_TIMER_ASSERT_SVH
`define FOUR_CHANNEL_PWM_TIMER_ASSERT_SVH

// checked only outside reset
`define PWMT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("four_channel_pwm_timer check failed");

// checked on every edge, reset included
`define PWMT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("four_channel_pwm_timer check failed");

`endif

// ----- hdl/pwmt_pkg.sv -----
// package for the four-channel pwm timer: sizes, request codes, word types
`default_nettype none

package pwmt_pkg;

   localparam int RESOLUTION = 1024;
   localparam int CHANNELS   = 4;

   localparam int CNT_W      = $clog2(RESOLUTION);
   localparam int RES_MAX    = RESOLUTION - 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_WRITE   = 3'd1,
      REQ_ENABLE  = 3'd2,
      REQ_DISABLE = 3'd3,
      REQ_UPDATE  = 3'd4
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESCALE_DIV = 1'd0,
      CSR_CHANNEL_MASK = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [1:0]  channel;
      logic [15:0] compare_value;
   } req_word_type;

   typedef struct packed {
      logic [3:0] pwm_out;
      logic [9:0] count_now;
      logic       update_event;
      logic       running;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- hdl/four_channel_pwm_timer.sv -----
// four-channel edge-aligned pwm timer top level
//
// Every request word (tick, compare write, enable, disable, forced update)
// is handled in the cycle it is accepted: the timer state updates at that
// edge and the response word is written into a two-word output buffer,
// whose head word drives rsp_data. One request word is accepted per
// cycle for as long as the buffer has room, so the rate is one word per
// cycle whenever the response side keeps taking words; req_ready drops only
// when both buffer words are waiting. Configuration writes are taken every
// cycle (csr_ready is always high) and act on the next request word.
`default_nettype none

module four_channel_pwm_timer (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  pwmt_pkg::req_word_type        req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output pwmt_pkg::rsp_word_type              rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [pwmt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [pwmt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = pwmt_pkg::CNT_W;

   logic [15:0]   div_ff;
   logic [3:0]    mask_ff;

   logic [15:0]   psc_ff, psc_in;
   logic [CW-1:0] per_ff, per_in;
   logic [CW-1:0] pre_ff [pwmt_pkg::CHANNELS];
   logic [CW-1:0] pre_in [pwmt_pkg::CHANNELS];
   logic [CW-1:0] act_ff [pwmt_pkg::CHANNELS];
   logic [CW-1:0] act_in [pwmt_pkg::CHANNELS];
   logic          run_ff, run_in;

   logic          upd;
   logic [CW-1:0] sat_val;
   logic [3:0]    lv;
   pwmt_pkg::rsp_word_type result;

   pwmt_pkg::rsp_word_type slot0_ff, slot1_ff;
   logic [1:0]    fill_ff;
   logic          push, pop;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff  <= '0;
         mask_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pwmt_pkg::CSR_PRESCALE_DIV: div_ff  <= csr_wdata;
            pwmt_pkg::CSR_CHANNEL_MASK: mask_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // next timer state
   always_comb begin
      psc_in = psc_ff;
      per_in = per_ff;
      run_in = run_ff;
      upd    = 1'b0;
      for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
         pre_in[i] = pre_ff[i];
         act_in[i] = act_ff[i];
      end
      if (32'(req_data.compare_value) > pwmt_pkg::RES_MAX) begin
         sat_val = CW'(pwmt_pkg::RES_MAX);
      end else begin
         sat_val = CW'(req_data.compare_value);
      end
      case (req_data.req_type)
         pwmt_pkg::REQ_TICK: begin
            if (run_ff) begin
               if (psc_ff >= div_ff) begin
                  psc_in = '0;
                  if (32'(per_ff) >= pwmt_pkg::RES_MAX) begin
                     per_in = '0;
                     upd    = 1'b1;
                     for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
                        act_in[i] = pre_ff[i];
                     end
                  end else begin
                     per_in = per_ff + CW'(1);
                  end
               end else begin
                  psc_in = psc_ff + 16'd1;
               end
            end
         end
         pwmt_pkg::REQ_WRITE: begin
            for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
               if (req_data.channel == 2'(i)) begin
                  pre_in[i] = sat_val;
               end
            end
         end
         pwmt_pkg::REQ_ENABLE: begin
            run_in = 1'b1;
         end
         pwmt_pkg::REQ_DISABLE: begin
            run_in = 1'b0;
            for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
               pre_in[i] = '0;
            end
         end
         pwmt_pkg::REQ_UPDATE: begin
            psc_in = '0;
            per_in = '0;
            upd    = 1'b1;
            for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
               act_in[i] = pre_ff[i];
            end
         end
         default: ;
      endcase
   end

   // output levels after the word
   always_comb begin
      lv = '0;
      for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
         lv[i] = run_in && mask_ff[i] && (per_in < act_in[i]);
      end
      result.pwm_out      = lv;
      result.count_now    = 10'(per_in);
      result.update_event = upd;
      result.running      = run_in;
   end

   assign push = req_valid && req_ready;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         psc_ff <= '0;
         per_ff <= '0;
         run_ff <= 1'b0;
         for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
            pre_ff[i] <= '0;
            act_ff[i] <= '0;
         end
      end else if (push) begin
         psc_ff <= psc_in;
         per_ff <= per_in;
         run_ff <= run_in;
         for (int i = 0; i < pwmt_pkg::CHANNELS; i++) begin
            pre_ff[i] <= pre_in[i];
            act_ff[i] <= act_in[i];
         end
      end
   end

   // two-word response buffer
   assign req_ready = (fill_ff != 2'd2);
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else if (push && !pop) begin
         fill_ff <= fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_ff <= fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (push && fill_ff == 2'd1) begin
            slot0_ff <= result;
         end else begin
            slot0_ff <= slot1_ff;
         end
         if (push && fill_ff == 2'd2) begin
            slot1_ff <= result;
         end
      end else if (push) begin
         if (fill_ff == 2'd0) begin
            slot0_ff <= result;
         end else begin
            slot1_ff <= result;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/pwmt_checker.sv -----
// port-level checker for the four-channel pwm timer, bound to the top level
`default_nettype none

`include "four_channel_pwm_timer_assert.svh"

module pwmt_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire pwmt_pkg::rsp_word_type       rsp_data
);

   // stopped timer drives no output
   `PWMT_ASSERT(a_low_when_stopped, rsp_valid |-> (rsp_data.running || rsp_data.pwm_out == 4'd0))

   // an update event always leaves the counter at zero
   `PWMT_ASSERT(a_update_at_zero, (rsp_valid && rsp_data.update_event) |-> (rsp_data.count_now == 10'd0))

   // a stalled response word holds
   `PWMT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))

   // nothing is shown right after reset
   `PWMT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind four_channel_pwm_timer pwmt_checker u_pwmt_checker (.*);

`default_nettype wire

// ----- dv/four_channel_pwm_timer_tb.sv -----
// testbench for the four-channel pwm timer: directed and random request words checked against a timer model
`default_nettype none

module four_channel_pwm_timer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         MAX_PRINTS   = 40;
   localparam int         CW           = pwmt_pkg::CNT_W;
   localparam int         CHN          = pwmt_pkg::CHANNELS;
   localparam int         RMAX         = pwmt_pkg::RES_MAX;
   localparam logic [2:0] REQ_SPARE_LO = 3'd5;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   pwmt_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   pwmt_pkg::rsp_word_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [pwmt_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pwmt_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // timer model state and register copies
   logic [15:0]          cfg_prescale_div = '0;
   logic [CHN-1:0]       cfg_channel_mask = '0;
   logic [15:0]          tm_prescale_cnt  = '0;
   logic [CW-1:0]        tm_period        = '0;
   logic [CW-1:0]        tm_preload [CHN];
   logic [CW-1:0]        tm_active [CHN];
   logic                 tm_running       = 1'b0;

   pwmt_pkg::rsp_word_type timer_rsp_q[$];

   int req_gap_pct    = 0;
   int rsp_stall_pct  = 0;
   int rsp_stall_left = 0;
   int mismatches     = 0;
   int words_sent     = 0;
   int rsp_checked    = 0;
   int period_wraps   = 0;
   int forced_updates = 0;

   four_channel_pwm_timer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("four_channel_pwm_timer_tb: done, errors");
      $finish;
   end

   // advances the timer model by one request word and returns its response word
   function automatic pwmt_pkg::rsp_word_type step_timer(input pwmt_pkg::req_word_type w);
      pwmt_pkg::rsp_word_type r;
      int i;
      r = '0;
      case (w.req_type)
         pwmt_pkg::REQ_TICK: begin
            if (tm_running) begin
               if (tm_prescale_cnt >= cfg_prescale_div) begin
                  tm_prescale_cnt = '0;
                  if (int'(tm_period) >= RMAX) begin
                     tm_period = '0;
                     for (i = 0; i < CHN; i++) tm_active[i] = tm_preload[i];
                     r.update_event = 1'b1;
                     period_wraps++;
                  end else begin
                     tm_period = tm_period + CW'(1);
                  end
               end else begin
                  tm_prescale_cnt = tm_prescale_cnt + 16'd1;
               end
            end
         end
         pwmt_pkg::REQ_WRITE: begin
            if (int'(w.channel) < CHN) begin
               if (int'(w.compare_value) > RMAX)
                  tm_preload[w.channel] = CW'(RMAX);
               else
                  tm_preload[w.channel] = w.compare_value[CW-1:0];
            end
         end
         pwmt_pkg::REQ_ENABLE: tm_running = 1'b1;
         pwmt_pkg::REQ_DISABLE: begin
            tm_running = 1'b0;
            for (i = 0; i < CHN; i++) tm_preload[i] = '0;
         end
         pwmt_pkg::REQ_UPDATE: begin
            tm_prescale_cnt = '0;
            tm_period = '0;
            for (i = 0; i < CHN; i++) tm_active[i] = tm_preload[i];
            r.update_event = 1'b1;
            forced_updates++;
         end
         default: ;
      endcase
      if (tm_running) begin
         for (i = 0; i < CHN; i++)
            if (cfg_channel_mask[i] && tm_period < tm_active[i]) r.pwm_out[i] = 1'b1;
      end
      r.count_now = tm_period;
      r.running = tm_running;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTS)
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (response %0d)",
                  $time, what, got, want, rsp_checked);
      mismatches++;
   endtask

   // response side: checks each word and stalls in random bursts
   always @(posedge clock) begin : rsp_side
      pwmt_pkg::rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_checked++;
            if (timer_rsp_q.size() == 0) begin
               report_mismatch("unexpected response word", int'(rsp_data), 0);
            end else begin
               want = timer_rsp_q.pop_front();
               if (rsp_data.pwm_out !== want.pwm_out)
                  report_mismatch("pwm_out", int'(rsp_data.pwm_out), int'(want.pwm_out));
               if (rsp_data.count_now !== want.count_now)
                  report_mismatch("count_now", int'(rsp_data.count_now),
                                  int'(want.count_now));
               if (rsp_data.update_event !== want.update_event)
                  report_mismatch("update_event", int'(rsp_data.update_event),
                                  int'(want.update_event));
               if (rsp_data.running !== want.running)
                  report_mismatch("running", int'(rsp_data.running), int'(want.running));
            end
         end
         if (rsp_stall_left != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
            rsp_stall_left = $urandom_range(0, 15);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic pause_req(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // leaves req_valid high so back-to-back words go out with no gap between them
   task automatic send_req(input logic [2:0] code, input logic [1:0] ch,
                           input logic [15:0] value);
      pwmt_pkg::req_word_type w;
      w.req_type = code;
      w.channel = ch;
      w.compare_value = value;
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct)
         pause_req($urandom_range(1, 16));
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      timer_rsp_q.push_back(step_timer(w));
      words_sent++;
   endtask

   task automatic drain_timer();
      req_valid <= 1'b0;
      while (timer_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input pwmt_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pwmt_pkg::CSR_PRESCALE_DIV: cfg_prescale_div = value;
         pwmt_pkg::CSR_CHANNEL_MASK: cfg_channel_mask = value[CHN-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_compare();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, RMAX));
         2: return 16'($urandom_range(RMAX - 2, RMAX + 2));
         default: return 16'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic send_random_req();
      int pick;
      logic [2:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 60)      code = pwmt_pkg::REQ_TICK;
      else if (pick < 75) code = pwmt_pkg::REQ_WRITE;
      else if (pick < 82) code = pwmt_pkg::REQ_ENABLE;
      else if (pick < 86) code = pwmt_pkg::REQ_DISABLE;
      else if (pick < 92) code = pwmt_pkg::REQ_UPDATE;
      else                code = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      send_req(code, 2'($urandom_range(0, 3)), rand_compare());
   endtask

   // every request code, saturation, stopped ticks, disable clearing preloads
   task automatic test_directed();
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      write_csr(pwmt_pkg::CSR_PRESCALE_DIV, 16'd0);
      write_csr(pwmt_pkg::CSR_CHANNEL_MASK, 16'hFFFF);
      send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'hFFFF);
      send_req(pwmt_pkg::REQ_WRITE, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_WRITE, 2'd1, 16'hFFFF);
      send_req(pwmt_pkg::REQ_WRITE, 2'd2, 16'(RMAX));
      send_req(pwmt_pkg::REQ_WRITE, 2'd3, 16'(RMAX + 1));
      send_req(pwmt_pkg::REQ_UPDATE, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_ENABLE, 2'd3, 16'hFFFF);
      repeat (3) send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
      send_req(REQ_SPARE_LO, 2'd3, 16'hFFFF);
      send_req(REQ_SPARE_LO + 3'd1, 2'd1, 16'h5555);
      send_req(REQ_SPARE_HI, 2'd2, 16'hAAAA);
      send_req(pwmt_pkg::REQ_WRITE, 2'd0, 16'd2);
      send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_UPDATE, 2'd0, 16'd0);
      repeat (2) send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_DISABLE, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_ENABLE, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_UPDATE, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
   endtask

   // prescaler division, a divider lowered below the running count, largest divider
   task automatic test_prescaler();
      drain_timer();
      write_csr(pwmt_pkg::CSR_PRESCALE_DIV, 16'd3);
      write_csr(pwmt_pkg::CSR_CHANNEL_MASK, 16'h5A3A);
      send_req(pwmt_pkg::REQ_WRITE, 2'd1, 16'd600);
      send_req(pwmt_pkg::REQ_UPDATE, 2'd0, 16'd0);
      repeat (2) send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
      drain_timer();
      write_csr(pwmt_pkg::CSR_PRESCALE_DIV, 16'd1);
      repeat (3) send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
      drain_timer();
      write_csr(pwmt_pkg::CSR_PRESCALE_DIV, 16'hFFFF);
      repeat (3) send_req(pwmt_pkg::REQ_TICK, 2'd0, 16'd0);
   endtask

   // random words under several register settings, each phase drained first
   task automatic test_random_mix();
      logic [15:0] div_set [4];
      logic [15:0] mask_set [4];
      int stall_set [4];
      int p;
      int n;
      div_set = '{16'd0, 16'hFFFF, 16'd2, 16'($urandom_range(0, 7))};
      mask_set = '{16'h000F, 16'hFFF0, 16'h0005, 16'($urandom)};
      stall_set = '{10, 25, 0, 15};
      for (p = 0; p < 4; p++) begin
         drain_timer();
         write_csr(pwmt_pkg::CSR_PRESCALE_DIV, div_set[p]);
         write_csr(pwmt_pkg::CSR_CHANNEL_MASK, mask_set[p]);
         rsp_stall_pct = stall_set[p];
         req_gap_pct = (p == 2) ? 0 : 15;
         for (n = 0; n < 60; n++) send_random_req();
      end
   endtask

   // long tick run that crosses a full period so the wrap loads the preloads
   task automatic test_period_wrap();
      int n;
      int i;
      drain_timer();
      write_csr(pwmt_pkg::CSR_PRESCALE_DIV, 16'd0);
      write_csr(pwmt_pkg::CSR_CHANNEL_MASK, 16'h000F);
      req_gap_pct = 10;
      rsp_stall_pct = 10;
      for (i = 0; i < CHN; i++)
         send_req(pwmt_pkg::REQ_WRITE, 2'(i), 16'($urandom_range(0, RMAX)));
      send_req(pwmt_pkg::REQ_UPDATE, 2'd0, 16'd0);
      send_req(pwmt_pkg::REQ_ENABLE, 2'd0, 16'd0);
      for (n = 0; n < 1080; n++) begin
         if (n == 750) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         if ($urandom_range(0, 99) < 3)
            send_req(pwmt_pkg::REQ_WRITE, 2'($urandom_range(0, 3)), rand_compare());
         else
            send_req(pwmt_pkg::REQ_TICK, 2'($urandom_range(0, 3)), 16'($urandom));
      end
   endtask

   initial begin : main
      int i;
      for (i = 0; i < CHN; i++) begin
         tm_preload[i] = '0;
         tm_active[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_prescaler();
      test_random_mix();
      test_period_wrap();
      drain_timer();
      repeat (8) @(posedge clock);
      $display("summary: %0d request words sent, %0d response words checked",
               words_sent, rsp_checked);
      $display("summary: %0d period wraps, %0d forced updates, %0d mismatches",
               period_wraps, forced_updates, mismatches);
      if (mismatches == 0)
         $display("four_channel_pwm_timer_tb: done, clean");
      else
         $display("four_channel_pwm_timer_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/pwmt_pkg.sv
hdl/four_channel_pwm_timer.sv
hdl/pwmt_checker.sv
dv/four_channel_pwm_timer_tb.sv
